@@ src/mtca_pkg.sv @@
// Package: sizes, command codes and address helpers for the transition counter.
`timescale 1ns / 1ps

package mtca_pkg;

   // Chain size and count storage width
   localparam int STATE_COUNT = 16;
   localparam int COUNT_WIDTH = 48;

   // Fixed field widths of the stream words
   localparam int STATE_W  = 4;
   localparam int WEIGHT_W = 16;
   localparam int EXT_W    = 48;
   localparam int CMD_W    = 2;

   // One memory holds the transition matrix followed by the initial vector
   localparam int TRANS_ENTRIES = STATE_COUNT * STATE_COUNT;
   localparam int ENTRY_COUNT   = TRANS_ENTRIES + STATE_COUNT;
   localparam int ADDR_W        = $clog2(ENTRY_COUNT);

   // Width that holds both an external count and a stored count
   localparam int CLIP_W = (COUNT_WIDTH > EXT_W) ? COUNT_WIDTH : EXT_W;

   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

   typedef enum logic [CMD_W-1:0] {
      CMD_OBSERVE = 2'd0,
      CMD_READ    = 2'd1,
      CMD_MERGE   = 2'd2
   } command_type;

   typedef logic [COUNT_WIDTH-1:0] count_type;
   typedef logic [ADDR_W-1:0]      addr_type;

   // Entry address of the transition from row to col
   function automatic addr_type trans_addr(input logic [STATE_W-1:0] row,
                                           input logic [STATE_W-1:0] col);
      logic [ADDR_W+STATE_W-1:0] prod;
      prod = (ADDR_W+STATE_W)'(row) * (ADDR_W+STATE_W)'(STATE_COUNT);
      return ADDR_W'(prod + (ADDR_W+STATE_W)'(col));
   endfunction

   // Entry address of the initial count of col
   function automatic addr_type init_addr(input logic [STATE_W-1:0] col);
      logic [ADDR_W+STATE_W-1:0] sum;
      sum = (ADDR_W+STATE_W)'(TRANS_ENTRIES) + (ADDR_W+STATE_W)'(col);
      return ADDR_W'(sum);
   endfunction

   // Clip an external count to the stored count range
   function automatic count_type clip_ext(input logic [EXT_W-1:0] ext);
      logic [CLIP_W-1:0] wide;
      wide = CLIP_W'(ext);
      if (wide > CLIP_W'(COUNT_MAX)) begin
         return COUNT_MAX;
      end
      return COUNT_WIDTH'(wide);
   endfunction

endpackage

@@ src/markov_transition_count_accumulator_unit.sv @@
// Pipeline: an accepted request word is held in the update stage with its registered memory
// read; its result word is then registered in the result register. Throughput: one word per
// cycle; the count memory's single read-modify-write path sets that, with the entry just
// written forwarded to a request that follows at once. A result word left waiting holds off
// new requests. Reset: synchronous, active high; clears the previous state and all handshake
// state, then a clearing pass zeroes all 272 entries, one per cycle, req_tready held low.
`timescale 1ns / 1ps

module markov_transition_count_accumulator_unit (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // state [3:0], row_state [7:4], weight [23:8], merge_count [71:24]
   input  logic [71:0]                        req_tdata,
   // command [1:0], use_initial [2], first [3]
   input  logic [3:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // count [47:0]
   output logic [mtca_pkg::EXT_W-1:0]         rsp_tdata,
   // saturated [0]
   output logic [0:0]                         rsp_tuser
);
   import mtca_pkg::*;

   // Unpacked request fields
   command_type            cmd_c;
   logic [STATE_W-1:0]     col_c;
   logic [STATE_W-1:0]     row_c;
   logic                   use_init_c;
   logic                   first_c;
   logic [WEIGHT_W-1:0]    weight_c;
   logic [EXT_W-1:0]       merge_c;

   // Decode stage
   logic                   accept_c;
   logic                   entry_c;
   logic                   add_c;
   logic                   prev_upd_c;
   addr_type               addr_c;
   count_type              addend_c;
   logic                   col_ok_c;
   logic                   row_ok_c;

   // Update stage
   logic                   s1_vld_ff, s1_vld_in;
   logic                   s1_entry_ff;
   logic                   s1_add_ff;
   addr_type               s1_addr_ff;
   count_type              s1_addend_ff;
   logic                   s1_go_c;
   logic                   fwd_hit_ff, fwd_hit_in;
   count_type              fwd_data_ff;
   count_type              rd_data_ff;
   count_type              old_c;
   logic [COUNT_WIDTH:0]   sum_c;
   logic                   sat_c;
   count_type              new_c;
   count_type              result_c;
   logic                   wr_en_c;

   // State
   count_type                  count_mem [ENTRY_COUNT];
   logic [STATE_W-1:0]         prev_state_ff, prev_state_in;

   // Clearing pass after reset
   logic                   clr_busy_ff, clr_busy_in;
   addr_type               clr_addr_ff, clr_addr_in;

   // Result register
   logic                   rsp_vld_ff, rsp_vld_in;
   logic [EXT_W-1:0]       rsp_count_ff;
   logic                   rsp_sat_ff;

   assign cmd_c      = command_type'(req_tuser[1:0]);
   assign use_init_c = req_tuser[2];
   assign first_c    = req_tuser[3];
   assign col_c      = req_tdata[3:0];
   assign row_c      = req_tdata[7:4];
   assign weight_c   = req_tdata[23:8];
   assign merge_c    = req_tdata[71:24];

   // Handshake: the update stage moves on when the result register is free
   assign s1_go_c    = s1_vld_ff && (!rsp_vld_ff || rsp_tready);
   assign req_tready = !clr_busy_ff && (!s1_vld_ff || s1_go_c);
   assign accept_c   = req_tvalid && req_tready;

   // Decode the command into an entry address and an addend
   assign col_ok_c = int'(col_c) < STATE_COUNT;
   assign row_ok_c = int'(row_c) < STATE_COUNT;

   always_comb begin
      entry_c    = 1'b0;
      add_c      = 1'b0;
      prev_upd_c = 1'b0;
      addr_c     = '0;
      addend_c   = '0;
      case (cmd_c)
         CMD_OBSERVE: begin
            if (col_ok_c && int'(prev_state_ff) < STATE_COUNT) begin
               entry_c    = 1'b1;
               add_c      = 1'b1;
               prev_upd_c = 1'b1;
               addend_c   = COUNT_WIDTH'(weight_c);
               addr_c     = first_c ? init_addr(col_c) : trans_addr(prev_state_ff, col_c);
            end
         end
         CMD_READ, CMD_MERGE: begin
            addend_c = clip_ext(merge_c);
            add_c    = (cmd_c == CMD_MERGE);
            if (use_init_c) begin
               entry_c = col_ok_c;
               addr_c  = col_ok_c ? init_addr(col_c) : '0;
            end else begin
               entry_c = col_ok_c && row_ok_c;
               addr_c  = (col_ok_c && row_ok_c) ? trans_addr(row_c, col_c) : '0;
            end
         end
         default: begin
            entry_c = 1'b0;
         end
      endcase
   end

   // Forward the value being written to an access of the same entry right behind it
   assign fwd_hit_in = accept_c && entry_c && s1_go_c && wr_en_c && (s1_addr_ff == addr_c);

   // Saturating add on the entry value
   assign old_c   = fwd_hit_ff ? fwd_data_ff : rd_data_ff;
   assign sum_c   = {1'b0, old_c} + {1'b0, s1_addend_ff};
   assign sat_c   = s1_entry_ff && s1_add_ff && sum_c[COUNT_WIDTH];
   assign new_c   = sum_c[COUNT_WIDTH] ? COUNT_MAX : sum_c[COUNT_WIDTH-1:0];
   assign wr_en_c = s1_vld_ff && s1_entry_ff && s1_add_ff;

   always_comb begin
      if (!s1_entry_ff) begin
         result_c = '0;
      end else if (s1_add_ff) begin
         result_c = new_c;
      end else begin
         result_c = old_c;
      end
   end

   // Next values of control registers
   always_comb begin
      s1_vld_in = s1_vld_ff;
      if (accept_c) begin
         s1_vld_in = 1'b1;
      end else if (s1_go_c) begin
         s1_vld_in = 1'b0;
      end
      rsp_vld_in = rsp_vld_ff;
      if (s1_go_c) begin
         rsp_vld_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_vld_in = 1'b0;
      end
      prev_state_in = (accept_c && prev_upd_c) ? col_c : prev_state_ff;
      // Advance the clearing pass, stop after the last entry
      clr_busy_in = clr_busy_ff;
      clr_addr_in = clr_addr_ff;
      if (clr_busy_ff) begin
         clr_addr_in = clr_addr_ff + addr_type'(1);
         if (clr_addr_ff == addr_type'(ENTRY_COUNT - 1)) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff     <= 1'b0;
         rsp_vld_ff    <= 1'b0;
         fwd_hit_ff    <= 1'b0;
         prev_state_ff <= '0;
         clr_busy_ff   <= 1'b1;
         clr_addr_ff   <= '0;
      end else begin
         s1_vld_ff     <= s1_vld_in;
         rsp_vld_ff    <= rsp_vld_in;
         prev_state_ff <= prev_state_in;
         clr_busy_ff   <= clr_busy_in;
         clr_addr_ff   <= clr_addr_in;
         if (accept_c || s1_go_c) begin
            fwd_hit_ff <= fwd_hit_in;
         end
      end
   end

   // Stage payload
   always_ff @(posedge clock) begin
      if (accept_c) begin
         s1_entry_ff  <= entry_c;
         s1_add_ff    <= add_c;
         s1_addr_ff   <= addr_c;
         s1_addend_ff <= addend_c;
         fwd_data_ff  <= new_c;
      end
      if (s1_go_c) begin
         rsp_count_ff <= EXT_W'(result_c);
         rsp_sat_ff   <= sat_c;
      end
   end

   // Count memory: registered read on accept, write back from the update stage
   always_ff @(posedge clock) begin
      if (accept_c) begin
         rd_data_ff <= count_mem[addr_c];
      end
   end

   // Zero the entries during the clearing pass, else write back the update
   always_ff @(posedge clock) begin
      if (clr_busy_ff) begin
         count_mem[clr_addr_ff] <= '0;
      end else if (s1_go_c && wr_en_c) begin
         count_mem[s1_addr_ff] <= new_c;
      end
   end

   assign rsp_tvalid   = rsp_vld_ff;
   assign rsp_tdata    = rsp_count_ff;
   assign rsp_tuser[0] = rsp_sat_ff;

`ifndef ASSERT_OFF
   // A clipped update always reports the maximum count
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tdata == EXT_W'(COUNT_MAX))
      else $error("saturated result without maximum count");

   // Forwarding only ever refers to a live update stage
   assert property (@(posedge clock) disable iff (reset)
      fwd_hit_ff |-> s1_vld_ff)
      else $error("forward hit with empty update stage");

   // A stalled update keeps its entry address
   assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !s1_go_c |=> s1_vld_ff && $stable(s1_addr_ff))
      else $error("update stage lost its entry while stalled");

   // Reads never clip
   assert property (@(posedge clock) disable iff (reset)
      s1_vld_ff && !s1_add_ff |-> !sat_c)
      else $error("read flagged as saturated");
`endif

endmodule
